// ----- rtl/core/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on clk, disabled while rst is high.
`define CHK_HOLDS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CHK_NEXT(label, ante, cons, msg) \
  `CHK_HOLDS(label, (ante) |=> (cons), msg)

`endif

// ----- rtl/core/b64p_pkg.sv -----
`timescale 1ns / 1ps

package b64p_pkg;

  localparam logic [1:0] PHASE_FIRST  = 2'd0;
  localparam logic [1:0] PHASE_SECOND = 2'd1;
  localparam logic [1:0] PHASE_THIRD  = 2'd2;

  localparam logic [7:0] PAD_CHAR     = 8'h3D;
  localparam logic [7:0] PERCENT_CHAR = 8'h25;

  typedef struct packed {
    logic [3:0][7:0] chars;
    logic [2:0]      count;
  } char_group_t;

  function automatic logic [7:0] b64_char(input logic [5:0] v);
    logic [7:0] w;
    w = {2'b00, v};
    if (v < 6'd26) begin
      return w + 8'h41;
    end else if (v < 6'd52) begin
      return w + 8'h47;
    end else if (v < 6'd62) begin
      return w - 8'd4;
    end else if (v == 6'd62) begin
      return 8'h2B;
    end else begin
      return 8'h2F;
    end
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    logic [7:0] w;
    w = {4'h0, n};
    if (n < 4'd10) begin
      return w + 8'h30;
    end else begin
      return w + 8'h37;
    end
  endfunction

  function automatic logic is_unreserved(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) ||
           (c >= 8'h30 && c <= 8'h39) ||
           c == 8'h2D || c == 8'h5F || c == 8'h2E || c == 8'h7E;
  endfunction

endpackage

// ----- rtl/core/b64p_encode.sv -----
`timescale 1ns / 1ps

module b64p_encode import b64p_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  logic [7:0]  data_byte,
  input  logic        final_byte,
  output char_group_t grp
);

  logic [1:0] group_phase;
  logic [1:0] group_phase_next;
  logic [3:0] leftover_bits;
  logic [3:0] leftover_bits_next;

  always_comb begin
    grp.chars = '0;
    grp.count = 3'd1;
    case (group_phase)
      PHASE_SECOND: begin
        grp.chars[0]       = b64_char({leftover_bits[1:0], data_byte[7:4]});
        grp.count          = 3'd1;
        group_phase_next   = PHASE_THIRD;
        leftover_bits_next = data_byte[3:0];
      end
      PHASE_THIRD: begin
        grp.chars[0]       = b64_char({leftover_bits, data_byte[7:6]});
        grp.chars[1]       = b64_char(data_byte[5:0]);
        grp.count          = 3'd2;
        group_phase_next   = PHASE_FIRST;
        leftover_bits_next = 4'h0;
      end
      default: begin
        grp.chars[0]       = b64_char(data_byte[7:2]);
        grp.count          = 3'd1;
        group_phase_next   = PHASE_SECOND;
        leftover_bits_next = {2'b00, data_byte[1:0]};
      end
    endcase
    if (final_byte) begin
      if (group_phase_next == PHASE_SECOND) begin
        grp.chars[1] = b64_char({leftover_bits_next[1:0], 4'h0});
        grp.chars[2] = PAD_CHAR;
        grp.chars[3] = PAD_CHAR;
        grp.count    = 3'd4;
      end else if (group_phase_next == PHASE_THIRD) begin
        grp.chars[1] = b64_char({leftover_bits_next, 2'b00});
        grp.chars[2] = PAD_CHAR;
        grp.count    = 3'd3;
      end
      group_phase_next   = PHASE_FIRST;
      leftover_bits_next = 4'h0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      group_phase   <= PHASE_FIRST;
      leftover_bits <= 4'h0;
    end else if (accept) begin
      group_phase   <= group_phase_next;
      leftover_bits <= leftover_bits_next;
    end
  end

endmodule

// ----- rtl/core/b64p_emit.sv -----
`timescale 1ns / 1ps

module b64p_emit import b64p_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        escape_enable,
  input  logic        load,
  input  char_group_t grp,
  output logic        load_ready,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_char,
  output logic        out_last
);

  logic        buf_valid;
  char_group_t buf_grp;
  logic [1:0]  idx;
  logic [1:0]  sub;

  logic [7:0]  cur_char;
  logic        cur_esc;
  logic        char_end;
  logic        run_end;
  logic        out_load;
  logic [7:0]  emit_char;

  assign cur_char = buf_grp.chars[idx];
  assign cur_esc  = escape_enable && !is_unreserved(cur_char);
  assign char_end = !cur_esc || (sub == 2'd2);
  assign run_end  = char_end && ({1'b0, idx} == buf_grp.count - 3'd1);
  assign out_load = buf_valid && (!out_valid || out_ready);
  assign load_ready = !buf_valid || (out_load && run_end);

  always_comb begin
    if (!cur_esc) begin
      emit_char = cur_char;
    end else begin
      case (sub)
        2'd0:    emit_char = PERCENT_CHAR;
        2'd1:    emit_char = hex_char(cur_char[7:4]);
        default: emit_char = hex_char(cur_char[3:0]);
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      buf_valid <= 1'b0;
      idx       <= 2'd0;
      sub       <= 2'd0;
    end else if (load) begin
      buf_valid <= 1'b1;
      idx       <= 2'd0;
      sub       <= 2'd0;
    end else if (out_load) begin
      if (char_end) begin
        idx <= idx + 2'd1;
        sub <= 2'd0;
      end else begin
        sub <= sub + 2'd1;
      end
      if (run_end) begin
        buf_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      buf_grp <= grp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_char <= emit_char;
      out_last <= run_end;
    end
  end

endmodule

// ----- rtl/core/base64_percent_stream_encoder_top.sv -----
`timescale 1ns / 1ps

// Base64 stream encoder with optional percent escaping. Each accepted byte
// is encoded into one to four base64 characters (with '=' padding on a final
// byte) and held in a group buffer; an output register sends them one
// character per cycle while out_ready allows, expanding '+', '/' and '=' to
// %HH when escape_enable is set. A taken byte's group goes into the group
// buffer, and its first character then goes into the output register.
// A byte produces 1 to 2 characters in plain mode (2 to 4 on a final byte)
// and up to 12 when escaping, so plain base64 averages 4/3 characters per
// byte and its rate is set by the single-character output port. The next byte is taken in the
// same cycle the previous group sends its last character.

module base64_percent_stream_encoder_top import b64p_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_wdata,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic       final_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_char,
  output logic       out_last
);

  logic        escape_enable;
  logic        accept;
  char_group_t grp;

  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      escape_enable <= 1'b1;
    end else if (cfg_we) begin
      escape_enable <= cfg_wdata;
    end
  end

  b64p_encode u_encode (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .data_byte  (data_byte),
    .final_byte (final_byte),
    .grp        (grp)
  );

  b64p_emit u_emit (
    .clk           (clk),
    .rst           (rst),
    .escape_enable (escape_enable),
    .load          (accept),
    .grp           (grp),
    .load_ready    (in_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_char      (out_char),
    .out_last      (out_last)
  );

endmodule

// ----- rtl/core/b64p_checker.sv -----
`timescale 1ns / 1ps

`include "assert_macros.svh"

module b64p_checker import b64p_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_char,
  input logic       out_last
);

  `CHK_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_char) && $stable(out_last), "output transaction changed while stalled")

  `CHK_HOLDS(a_char_set, out_valid |-> ((out_char >= 8'h41 && out_char <= 8'h5A) || (out_char >= 8'h61 && out_char <= 8'h7A) || (out_char >= 8'h30 && out_char <= 8'h39) || out_char == 8'h2B || out_char == 8'h2F || out_char == PAD_CHAR || out_char == PERCENT_CHAR), "output character outside encoder alphabet")

  `CHK_NEXT(a_run_gapless, out_valid && out_ready && !out_last, out_valid, "gap inside a character run")

  `CHK_HOLDS(a_rise_after_input, $rose(out_valid) |-> $past(in_valid && in_ready, 2), "output without an input transaction")

endmodule

bind base64_percent_stream_encoder_top b64p_checker u_b64p_checker (.*);

// ----- tb/base64_percent_stream_encoder_top_tb.sv -----
`timescale 1ns / 1ps

module base64_percent_stream_encoder_top_tb;
  import b64p_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 8;

  logic       clk;
  logic       rst = 1'b1;
  logic       cfg_we = 1'b0;
  logic       cfg_wdata = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] data_byte = 8'h00;
  logic       final_byte = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_char;
  logic       out_last;

  string b64_alpha = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
  string hex_digits = "0123456789ABCDEF";

  bit [7:0] exp_chars[$];
  bit       exp_lasts[$];

  logic       esc_on;
  logic [1:0] grp_phase;
  logic [3:0] carry_bits;

  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  int mismatches = 0;
  int cycle_count = 0;

  base64_percent_stream_encoder_top u_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .data_byte  (data_byte),
    .final_byte (final_byte),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_char   (out_char),
    .out_last   (out_last)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("base64_percent_stream_encoder_top regression: fail");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch: %s got 0x%0h expected 0x%0h", what, got, want);
    mismatches++;
  endtask

  function automatic bit char_is_unreserved(input bit [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") ||
           (c >= "0" && c <= "9") ||
           c == "-" || c == "_" || c == "." || c == "~";
  endfunction

  task automatic push_enc_char(input bit [7:0] c);
    if (esc_on && !char_is_unreserved(c)) begin
      exp_chars.push_back(PERCENT_CHAR);
      exp_lasts.push_back(1'b0);
      exp_chars.push_back(hex_digits[c[7:4]]);
      exp_lasts.push_back(1'b0);
      exp_chars.push_back(hex_digits[c[3:0]]);
      exp_lasts.push_back(1'b0);
    end else begin
      exp_chars.push_back(c);
      exp_lasts.push_back(1'b0);
    end
  endtask

  task automatic push_sextet(input bit [5:0] v);
    push_enc_char(b64_alpha[v]);
  endtask

  task automatic predict_encoding(input bit [7:0] b, input bit fin);
    case (grp_phase)
      PHASE_SECOND: begin
        push_sextet({carry_bits[1:0], b[7:4]});
        carry_bits = b[3:0];
        grp_phase = PHASE_THIRD;
      end
      PHASE_THIRD: begin
        push_sextet({carry_bits, b[7:6]});
        push_sextet(b[5:0]);
        carry_bits = 4'h0;
        grp_phase = PHASE_FIRST;
      end
      default: begin
        push_sextet(b[7:2]);
        carry_bits = {2'b00, b[1:0]};
        grp_phase = PHASE_SECOND;
      end
    endcase
    if (fin) begin
      if (grp_phase == PHASE_SECOND) begin
        push_sextet({carry_bits[1:0], 4'h0});
        push_enc_char(PAD_CHAR);
        push_enc_char(PAD_CHAR);
      end else if (grp_phase == PHASE_THIRD) begin
        push_sextet({carry_bits, 2'b00});
        push_enc_char(PAD_CHAR);
      end
      grp_phase = PHASE_FIRST;
      carry_bits = 4'h0;
    end
    exp_lasts[exp_lasts.size() - 1] = 1'b1;
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (exp_chars.size() == 0) begin
        report_mismatch("unexpected out_char", out_char, 0);
      end else begin
        if (out_char !== exp_chars[0]) begin
          report_mismatch("out_char", out_char, exp_chars[0]);
        end
        if (out_last !== exp_lasts[0]) begin
          report_mismatch("out_last", out_last, exp_lasts[0]);
        end
        void'(exp_chars.pop_front());
        void'(exp_lasts.pop_front());
      end
    end
  end

  task automatic send_byte(input bit [7:0] b, input bit fin);
    @(negedge clk);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    final_byte <= fin;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_encoding(b, fin);
  endtask

  task automatic wait_for_drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (exp_chars.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_escape(input bit value);
    wait_for_drain();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    esc_on = value;
  endtask

  task automatic send_message(input bit [7:0] bytes[$]);
    foreach (bytes[i]) send_byte(bytes[i], i == bytes.size() - 1);
  endtask

  task automatic test_directed_messages();
    send_message('{8'h00});
    send_message('{8'hFF});
    send_message('{8'hFB, 8'hFF});
    send_message('{8'h00, 8'hFF, 8'hFB});
    send_message('{8'hFF, 8'hFF, 8'hFF, 8'hFF});
  endtask

  task automatic test_reset_escape_default();
    test_directed_messages();
  endtask

  task automatic test_plain_directed();
    write_escape(1'b0);
    test_directed_messages();
  endtask

  function automatic bit [7:0] pick_byte();
    bit [7:0] special[6] = '{8'hFF, 8'hFB, 8'hFC, 8'h03, 8'h3F, 8'hF8};
    if ($urandom_range(0, 3) == 0) return special[$urandom_range(0, 5)];
    return 8'($urandom);
  endfunction

  task automatic run_random_traffic(input int n_bytes, input bit pause_midway);
    int sent;
    int len;
    sent = 0;
    while (sent < n_bytes) begin
      len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : $urandom_range(1, 9);
      for (int i = 0; i < len; i++) begin
        send_byte(pick_byte(), i == len - 1);
      end
      sent += len;
      if (pause_midway && sent >= n_bytes / 2) begin
        wait_for_drain();
        pause_midway = 1'b0;
      end
    end
  endtask

  task automatic test_random_no_idle();
    write_escape(1'b1);
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    run_random_traffic(90, 1'b0);
  endtask

  task automatic test_random_sender_idle();
    write_escape(1'b0);
    sender_idle_pct = 77;
    receiver_stall_pct = 0;
    run_random_traffic(90, 1'b1);
  endtask

  task automatic test_random_receiver_stall();
    write_escape(1'b1);
    sender_idle_pct = 0;
    receiver_stall_pct = 77;
    run_random_traffic(90, 1'b0);
  endtask

  task automatic test_random_both_idle();
    write_escape(1'b0);
    sender_idle_pct = 35;
    receiver_stall_pct = 35;
    run_random_traffic(45, 1'b0);
    write_escape(1'b1);
    run_random_traffic(45, 1'b0);
  endtask

  initial begin
    esc_on = 1'b1;
    grp_phase = PHASE_FIRST;
    carry_bits = 4'h0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_escape_default();
    test_plain_directed();
    test_random_no_idle();
    test_random_sender_idle();
    test_random_receiver_stall();
    test_random_both_idle();

    wait_for_drain();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("base64_percent_stream_encoder_top regression: pass");
    end else begin
      $display("base64_percent_stream_encoder_top regression: fail");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/b64p_pkg.sv
rtl/core/b64p_encode.sv
rtl/core/b64p_emit.sv
rtl/core/base64_percent_stream_encoder_top.sv
rtl/core/b64p_checker.sv
tb/base64_percent_stream_encoder_top_tb.sv
